// ===== src/plc_pkg.sv =====
// Shared constants and types of the point light contribution unit.
`default_nettype none
package plc_pkg;

   localparam int Lanes      = 3;
   localparam int RootSteps  = 34;   // result bits of the square root
   localparam int ColorSteps = 32;   // quotient bits of the color divide
   localparam int DirSteps   = 31;   // quotient bits of the direction divide
   localparam int SumW       = 68;
   localparam int CremW      = 80;
   localparam int DremW      = 64;

   typedef struct packed {
      logic signed [2:0][31:0] hit;
      logic signed [2:0][31:0] light;
      logic [2:0][31:0]        color;
      logic [31:0]             power;
      logic                    last;
   } plc_in_type;

   // Everything one request carries down the cell chain.
   typedef struct packed {
      logic                            valid;
      logic                            last;
      logic                            zero;
      logic [Lanes-1:0]                neg;
      logic [Lanes-1:0][32:0]          mag;
      logic [SumW-1:0]                 s;
      logic [RootSteps-1:0]            root;
      logic [SumW-1:0]                 srem;
      logic [Lanes-1:0][CremW-1:0]     crem;
      logic [Lanes-1:0][ColorSteps-1:0] cq;
      logic [Lanes-1:0]                sat;
      logic [Lanes-1:0][DremW-1:0]     drem;
      logic [Lanes-1:0][DirSteps-1:0]  dq;
   } plc_token_type;

endpackage
`default_nettype wire

// ===== src/plc_if.sv =====
// Request and response channel interfaces.
`default_nettype none
interface plc_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] hit_x;
   logic signed [31:0] hit_y;
   logic signed [31:0] hit_z;
   logic signed [31:0] light_x;
   logic signed [31:0] light_y;
   logic signed [31:0] light_z;
   logic [31:0]        light_red;
   logic [31:0]        light_green;
   logic [31:0]        light_blue;
   logic [31:0]        light_power;
   logic               last_light;
   modport source (output valid, hit_x, hit_y, hit_z, light_x, light_y, light_z,
                   light_red, light_green, light_blue, light_power, last_light,
                   input ready);
   modport sink (input valid, hit_x, hit_y, hit_z, light_x, light_y, light_z,
                 light_red, light_green, light_blue, light_power, last_light,
                 output ready);
endinterface

interface plc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] dir_x;
   logic signed [31:0] dir_y;
   logic signed [31:0] dir_z;
   logic [33:0]        distance;
   logic [31:0]        color_red;
   logic [31:0]        color_green;
   logic [31:0]        color_blue;
   logic               zero_distance;
   logic               last_result;
   modport source (output valid, dir_x, dir_y, dir_z, distance, color_red,
                   color_green, color_blue, zero_distance, last_result,
                   input ready);
   modport sink (input valid, dir_x, dir_y, dir_z, distance, color_red,
                 color_green, color_blue, zero_distance, last_result,
                 output ready);
endinterface
`default_nettype wire

// ===== src/point_light_contribution_unit.sv =====
// Top level of the point light contribution unit.
//
//  channel  | dir | handshake        | payload
//  req_ch   | in  | valid / ready    | hit xyz, light xyz, rgb, power, last_light
//  rsp_ch   | out | valid / ready    | dir xyz, distance, rgb, zero_distance, last
//
// Takes one request per cycle unless the response side stalls; the chain is
// three front stages, 34 square root cells (one root bit each) and 31 divide
// cells (one direction bit each). The last cell register drives the response.
// Reset clears only the valid bits of the chain.
// While a response waits unaccepted the whole chain holds.
`default_nettype none
module point_light_contribution_unit
   import plc_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   plc_req_if.sink    req_ch,
   plc_rsp_if.source  rsp_ch
);

   localparam int NumCells = RootSteps + DirSteps;

   plc_in_type    in_data;
   plc_token_type chain [NumCells+1];
   plc_token_type tail;
   logic          adv;

   assign tail = chain[NumCells];
   assign adv  = !tail.valid || rsp_ch.ready;
   assign req_ch.ready = adv;

   assign in_data.hit[0]   = req_ch.hit_x;
   assign in_data.hit[1]   = req_ch.hit_y;
   assign in_data.hit[2]   = req_ch.hit_z;
   assign in_data.light[0] = req_ch.light_x;
   assign in_data.light[1] = req_ch.light_y;
   assign in_data.light[2] = req_ch.light_z;
   assign in_data.color[0] = req_ch.light_red;
   assign in_data.color[1] = req_ch.light_green;
   assign in_data.color[2] = req_ch.light_blue;
   assign in_data.power    = req_ch.light_power;
   assign in_data.last     = req_ch.last_light;

   plc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_ch.valid),
      .in_data  (in_data),
      .tok_out  (chain[0])
   );

   for (genvar g = 0; g < RootSteps; g++) begin : g_root
      plc_root_cell u_cell (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .step  (6'(g)),
         .tok_i (chain[g]),
         .tok_o (chain[g+1])
      );
   end

   for (genvar g = 0; g < DirSteps; g++) begin : g_dir
      plc_dir_cell u_cell (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .step  (5'(g)),
         .tok_i (chain[RootSteps+g]),
         .tok_o (chain[RootSteps+g+1])
      );
   end

   logic [Lanes-1:0][31:0] dir_val;
   logic [Lanes-1:0][31:0] col_val;

   always_comb begin
      for (int k = 0; k < Lanes; k++) begin
         dir_val[k] = tail.neg[k] ? 32'(-{1'b0, tail.dq[k]}) : {1'b0, tail.dq[k]};
         col_val[k] = tail.sat[k] ? 32'hFFFF_FFFF : tail.cq[k];
         // drop everything for a coincident light
         if (tail.zero) begin
            dir_val[k] = '0;
            col_val[k] = '0;
         end
      end
   end

   assign rsp_ch.valid         = tail.valid;
   assign rsp_ch.dir_x         = dir_val[0];
   assign rsp_ch.dir_y         = dir_val[1];
   assign rsp_ch.dir_z         = dir_val[2];
   assign rsp_ch.distance      = tail.zero ? 34'd0 : tail.root;
   assign rsp_ch.color_red     = col_val[0];
   assign rsp_ch.color_green   = col_val[1];
   assign rsp_ch.color_blue    = col_val[2];
   assign rsp_ch.zero_distance = tail.zero;
   assign rsp_ch.last_result   = tail.last;

   a_root_nonzero: assert property (@(posedge clock) disable iff (reset)
      tail.valid && !tail.zero |-> tail.root != '0)
      else $error("nonzero distance gave zero root");

   a_dir_range: assert property (@(posedge clock) disable iff (reset)
      tail.valid && !tail.zero |-> tail.dq[0] <= 31'h4000_0000 &&
         tail.dq[1] <= 31'h4000_0000 && tail.dq[2] <= 31'h4000_0000)
      else $error("direction quotient above one");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(chain[0]) && $stable(tail))
      else $error("chain moved during stall");

endmodule
`default_nettype wire

// ===== src/plc_front.sv =====
// Front stages: differences, squares and products, squared distance.
`default_nettype none
module plc_front
   import plc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          adv,
   input  wire logic          in_valid,
   input  wire plc_in_type    in_data,
   output plc_token_type      tok_out
);

   logic                      s1_valid_ff;
   logic [Lanes-1:0][32:0]    s1_mag_ff, s1_mag_in;
   logic [Lanes-1:0]          s1_neg_ff, s1_neg_in;
   logic [Lanes-1:0][31:0]    s1_col_ff;
   logic [31:0]               s1_pow_ff;
   logic                      s1_last_ff;

   logic                      s2_valid_ff;
   logic [Lanes-1:0][32:0]    s2_mag_ff;
   logic [Lanes-1:0]          s2_neg_ff;
   logic [Lanes-1:0][65:0]    s2_sq_ff, s2_sq_in;
   logic [Lanes-1:0][63:0]    s2_cp_ff, s2_cp_in;
   logic                      s2_last_ff;

   plc_token_type             tok_ff, tok_in;

   always_comb begin
      logic signed [32:0] d;
      for (int k = 0; k < Lanes; k++) begin
         d = {in_data.light[k][31], in_data.light[k]} - {in_data.hit[k][31], in_data.hit[k]};
         s1_neg_in[k] = d[32];
         s1_mag_in[k] = d[32] ? 33'(-d) : 33'(d);
      end
   end

   always_comb begin
      for (int k = 0; k < Lanes; k++) begin
         s2_sq_in[k] = {33'b0, s1_mag_ff[k]} * {33'b0, s1_mag_ff[k]};
         s2_cp_in[k] = {32'b0, s1_col_ff[k]} * {32'b0, s1_pow_ff};
      end
   end

   always_comb begin
      logic [SumW-1:0] sum;
      sum = {2'b0, s2_sq_ff[0]} + {2'b0, s2_sq_ff[1]} + {2'b0, s2_sq_ff[2]};
      tok_in       = '0;
      tok_in.valid = s2_valid_ff;
      tok_in.last  = s2_last_ff;
      tok_in.zero  = (sum == '0);
      tok_in.neg   = s2_neg_ff;
      tok_in.mag   = s2_mag_ff;
      tok_in.s     = sum;
      tok_in.srem  = sum;
      for (int k = 0; k < Lanes; k++) begin
         tok_in.crem[k] = {s2_cp_ff[k], 16'b0};
         // quotient of 2^32 or more saturates
         tok_in.sat[k]  = {18'b0, s2_cp_ff[k], 16'b0} >= ({30'b0, sum} << 32);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         tok_ff      <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_mag_ff  <= s1_mag_in;
         s1_neg_ff  <= s1_neg_in;
         s1_col_ff  <= in_data.color;
         s1_pow_ff  <= in_data.power;
         s1_last_ff <= in_data.last;
         s2_mag_ff  <= s1_mag_ff;
         s2_neg_ff  <= s1_neg_ff;
         s2_sq_ff   <= s2_sq_in;
         s2_cp_ff   <= s2_cp_in;
         s2_last_ff <= s1_last_ff;
      end
   end

   assign tok_out = tok_ff;

endmodule
`default_nettype wire

// ===== src/plc_root_cell.sv =====
// One square root bit and, while step is below ColorSteps, one color quotient bit per lane.
`default_nettype none
module plc_root_cell
   import plc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          adv,
   input  wire logic [5:0]    step,
   input  wire plc_token_type tok_i,
   output plc_token_type      tok_o
);

   plc_token_type tok_ff, tok_in;

   always_comb begin
      logic [6:0]      bit_pos;
      logic [SumW-1:0] test;
      logic [4:0]      cbit;
      logic [97:0]     t;
      logic [97:0]     r;
      tok_in  = tok_i;
      bit_pos = 7'(RootSteps - 1) - {1'b0, step};
      // (res + 2^b)^2 - res^2 = res*2^(b+1) + 2^(2b)
      test = ({34'b0, tok_i.root} << (bit_pos + 7'd1)) + (68'd1 << {bit_pos, 1'b0});
      if (tok_i.srem >= test) begin
         tok_in.srem = tok_i.srem - test;
         tok_in.root = tok_i.root | (34'd1 << bit_pos);
      end
      cbit = 5'(ColorSteps - 1) - step[4:0];
      for (int k = 0; k < Lanes; k++) begin
         t = {30'b0, tok_i.s} << cbit;
         r = {18'b0, tok_i.crem[k]};
         if (step < 6'(ColorSteps) && r >= t) begin
            tok_in.crem[k] = tok_i.crem[k] - t[CremW-1:0];
            tok_in.cq[k]   = tok_i.cq[k] | (32'd1 << cbit);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (adv) begin
         tok_ff <= tok_in;
      end
   end

   assign tok_o = tok_ff;

endmodule
`default_nettype wire

// ===== src/plc_dir_cell.sv =====
// One direction quotient bit per lane: mag * 2^30 / distance.
`default_nettype none
module plc_dir_cell
   import plc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          adv,
   input  wire logic [4:0]    step,
   input  wire plc_token_type tok_i,
   output plc_token_type      tok_o
);

   plc_token_type tok_ff, tok_in;

   always_comb begin
      logic [4:0]       qbit;
      logic [DremW-1:0] t;
      logic [DremW-1:0] r;
      tok_in = tok_i;
      qbit   = 5'(DirSteps - 1) - step;
      t      = {30'b0, tok_i.root} << qbit;
      for (int k = 0; k < Lanes; k++) begin
         // load the dividend in the first cell
         r = (step == 5'd0) ? {1'b0, tok_i.mag[k], 30'b0} : tok_i.drem[k];
         tok_in.drem[k] = r;
         if (step == 5'd0) tok_in.dq[k] = '0;
         if (r >= t) begin
            tok_in.drem[k] = r - t;
            tok_in.dq[k]   = tok_in.dq[k] | (31'd1 << qbit);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (adv) begin
         tok_ff <= tok_in;
      end
   end

   assign tok_o = tok_ff;

endmodule
`default_nettype wire

// ===== sim/tb_point_light_contribution_unit.sv =====
// Self-checking testbench of the point light contribution unit.
`default_nettype none
module tb_point_light_contribution_unit;
   import plc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [31:0] dir_x, dir_y, dir_z;
      logic [33:0]        distance;
      logic [31:0]        red, green, blue;
      logic               zero;
      logic               last;
   } light_result_type;

   class contribution_board;
      light_result_type pending[$];

      function automatic light_result_type shade(plc_in_type req);
         light_result_type r;
         logic [32:0]  mag[3];
         logic         neg[3];
         logic [67:0]  sum;
         logic [33:0]  root;
         logic [33:0]  cand;
         logic [67:0]  sq;
         logic [63:0]  q;
         logic [127:0] num, cq;
         logic [31:0]  col[3];
         logic signed [33:0] d;
         sum = '0;
         for (int k = 0; k < 3; k++) begin
            d = $signed({req.light[k][31], req.light[k]}) - $signed({req.hit[k][31], req.hit[k]});
            neg[k] = d[33];
            mag[k] = neg[k] ? 33'(-d) : 33'(d);
            sum = sum + {35'b0, mag[k]} * {35'b0, mag[k]};
         end
         r.last = req.last;
         if (sum == '0) begin
            r.dir_x = '0; r.dir_y = '0; r.dir_z = '0;
            r.distance = '0; r.red = '0; r.green = '0; r.blue = '0;
            r.zero = 1'b1;
            return r;
         end
         root = '0;
         for (int b = 33; b >= 0; b--) begin
            cand = root | (34'd1 << b);
            sq = {34'b0, cand} * {34'b0, cand};
            if (sum >= sq) root = cand;
         end
         for (int k = 0; k < 3; k++) begin
            q = ({31'b0, mag[k]} << 30) / {30'b0, root};
            q = neg[k] ? -q : q;
            if (k == 0) r.dir_x = q[31:0];
            else if (k == 1) r.dir_y = q[31:0];
            else r.dir_z = q[31:0];
         end
         r.distance = root;
         for (int k = 0; k < 3; k++) begin
            num = ({96'b0, req.color[k]} * {96'b0, req.power}) << 16;
            cq = num / {60'b0, sum};
            col[k] = (cq >= (128'd1 << 32)) ? 32'hFFFF_FFFF : cq[31:0];
         end
         r.red = col[0]; r.green = col[1]; r.blue = col[2];
         r.zero = 1'b0;
         return r;
      endfunction

      function void note_request(plc_in_type req);
         pending.push_back(shade(req));
      endfunction

      // Return an empty string on a match, else what went wrong.
      function string check_response(light_result_type got);
         light_result_type e;
         string msg;
         if (pending.size() == 0) return "response with no request waiting";
         e = pending.pop_front();
         msg = "";
         if (got.dir_x !== e.dir_x) msg = {msg, $sformatf(" dir_x %h/%h", got.dir_x, e.dir_x)};
         if (got.dir_y !== e.dir_y) msg = {msg, $sformatf(" dir_y %h/%h", got.dir_y, e.dir_y)};
         if (got.dir_z !== e.dir_z) msg = {msg, $sformatf(" dir_z %h/%h", got.dir_z, e.dir_z)};
         if (got.distance !== e.distance)
            msg = {msg, $sformatf(" distance %h/%h", got.distance, e.distance)};
         if (got.red !== e.red) msg = {msg, $sformatf(" red %h/%h", got.red, e.red)};
         if (got.green !== e.green) msg = {msg, $sformatf(" green %h/%h", got.green, e.green)};
         if (got.blue !== e.blue) msg = {msg, $sformatf(" blue %h/%h", got.blue, e.blue)};
         if (got.zero !== e.zero) msg = {msg, $sformatf(" zero %b/%b", got.zero, e.zero)};
         if (got.last !== e.last) msg = {msg, $sformatf(" last %b/%b", got.last, e.last)};
         return msg;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   mismatches = 0;
   int   stall_left = 0;
   int   ready_mode = 0;
   contribution_board board = new();

   plc_req_if req_ch();
   plc_rsp_if rsp_ch();

   point_light_contribution_unit uut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   always #10 clock = ~clock;

   task automatic report(string what);
      $display("mismatch at %0t:%s", $realtime, what);
      mismatches++;
   endtask

   // Sample both channels at the rising edge.
   always @(posedge clock) begin
      plc_in_type req;
      light_result_type got;
      string msg;
      if (!reset && req_ch.valid && req_ch.ready) begin
         req.hit   = '{req_ch.hit_z, req_ch.hit_y, req_ch.hit_x};
         req.light = '{req_ch.light_z, req_ch.light_y, req_ch.light_x};
         req.color = '{req_ch.light_blue, req_ch.light_green, req_ch.light_red};
         req.power = req_ch.light_power;
         req.last  = req_ch.last_light;
         board.note_request(req);
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.dir_x = rsp_ch.dir_x; got.dir_y = rsp_ch.dir_y; got.dir_z = rsp_ch.dir_z;
         got.distance = rsp_ch.distance;
         got.red = rsp_ch.color_red; got.green = rsp_ch.color_green;
         got.blue = rsp_ch.color_blue;
         got.zero = rsp_ch.zero_distance; got.last = rsp_ch.last_result;
         msg = board.check_response(got);
         if (msg != "") report(msg);
      end
   end

   // Receiver: runs of full rate, random stalls and long holds.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ch.ready = 1'b0;
         stall_left--;
      end else begin
         if ($urandom_range(0, 99) == 0) ready_mode = $urandom_range(0, 2);
         case (ready_mode)
            0: rsp_ch.ready = 1'b1;
            1: rsp_ch.ready = 1'($urandom_range(0, 1));
            default: begin
               rsp_ch.ready = 1'b1;
               if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(1, 20);
            end
         endcase
      end
   end

   // Drive one request; return at the falling edge after it is taken.
   task automatic push(plc_in_type req);
      {req_ch.hit_z, req_ch.hit_y, req_ch.hit_x} = req.hit;
      {req_ch.light_z, req_ch.light_y, req_ch.light_x} = req.light;
      {req_ch.light_blue, req_ch.light_green, req_ch.light_red} = req.color;
      req_ch.light_power = req.power;
      req_ch.last_light  = req.last;
      req_ch.valid = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic pace(inout int burst);
      if (burst > 0) begin
         burst--;
      end else begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(10, 40);
      end
   endtask

   function automatic logic [31:0] rand_coord(int kind);
      case (kind)
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 65536 * 8)) - 65536 * 4);
         default: return 32'($signed($urandom_range(0, 4096)) - 2048);
      endcase
   endfunction

   function automatic plc_in_type random_request();
      plc_in_type r;
      int kind;
      int pick;
      kind = $urandom_range(0, 2);
      for (int k = 0; k < 3; k++) begin
         r.hit[k] = $urandom();
         r.light[k] = r.hit[k] + rand_coord(kind);
         r.color[k] = $urandom_range(0, 3) == 0 ? $urandom() : 32'($urandom_range(0, 1 << 18));
      end
      pick = $urandom_range(0, 19);
      if (pick == 0) r.light = r.hit;
      else if (pick == 1) for (int k = 0; k < 3; k++) r.light[k] = $urandom();
      r.power = $urandom_range(0, 3) == 0 ? $urandom() : 32'($urandom_range(0, 1 << 20));
      r.last = 1'($urandom_range(0, 1));
      return r;
   endfunction

   function automatic plc_in_type make_req(logic [31:0] h, logic [31:0] l,
                                           logic [31:0] c, logic [31:0] p, logic last);
      plc_in_type r;
      r.hit = '{h, h, h};
      r.light = '{l, l, l};
      r.color = '{c, c, c};
      r.power = p;
      r.last = last;
      return r;
   endfunction

   initial begin
      plc_in_type dir[$];
      plc_in_type r;
      int burst;
      req_ch.valid = 1'b0;
      {req_ch.hit_x, req_ch.hit_y, req_ch.hit_z} = '0;
      {req_ch.light_x, req_ch.light_y, req_ch.light_z} = '0;
      {req_ch.light_red, req_ch.light_green, req_ch.light_blue} = '0;
      req_ch.light_power = '0;
      req_ch.last_light = 1'b0;
      rsp_ch.ready = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: coincident points, extremes, saturation, single axes.
      dir.push_back(make_req(32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
      dir.push_back(make_req(32'h8000_0000, 32'h8000_0000, 32'h1_0000, 32'h1_0000, 1'b0));
      dir.push_back(make_req(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
      dir.push_back(make_req(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
      dir.push_back(make_req(32'h0, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
      dir.push_back(make_req(32'h0, 32'h1, 32'h0, 32'h0, 1'b0));
      dir.push_back(make_req(32'h0, 32'h1_0000, 32'h1_0000, 32'h1_0000, 1'b1));
      dir.push_back(make_req(32'h1_0000, 32'h0, 32'h1, 32'h1, 1'b0));
      dir.push_back(make_req(32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h2, 1'b1));
      dir.push_back(make_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b0));
      for (int k = 0; k < 3; k++) begin
         r = make_req(32'h0, 32'h0, 32'h1_0000, 32'h4_0000, k[0]);
         r.light[k] = 32'h2_0000;
         dir.push_back(r);
         r.light[k] = 32'hFFFE_0000;
         dir.push_back(r);
         r.light[k] = 32'h8000_0000;
         r.hit[k] = 32'h7FFF_FFFF;
         dir.push_back(r);
      end
      r = make_req(32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      r.color = '{32'h0, 32'h1234_5678, 32'hFFFF_FFFF};
      r.light = '{32'h3_0000, 32'hFFFC_0000, 32'h5_0000};
      dir.push_back(r);
      foreach (dir[i]) push(dir[i]);

      burst = 0;
      for (int n = 0; n < 1850; n++) begin
         push(random_request());
         pace(burst);
      end
      req_ch.valid = 1'b0;
      wait (board.pending.size() == 0);
      repeat (80) @(posedge clock);
      if (board.pending.size() != 0) report("requests left without a response");
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
`default_nettype wire

// ===== sim.f =====
src/plc_pkg.sv
src/plc_if.sv
src/plc_front.sv
src/plc_root_cell.sv
src/plc_dir_cell.sv
src/point_light_contribution_unit.sv
sim/tb_point_light_contribution_unit.sv
